// ===== rtl/ois_pkg.sv =====
`default_nettype none

package ois_pkg;

    localparam int KEY_W      = 16;
    localparam int BIT_AW     = 6;
    localparam int WORD_W     = 64;
    localparam int LEAF_AW    = KEY_W - BIT_AW;
    localparam int MID_AW     = LEAF_AW - BIT_AW;
    localparam int LEAF_WORDS = 1 << LEAF_AW;
    localparam int MID_WORDS  = 1 << MID_AW;
    localparam int LIMIT_W    = KEY_W + 1;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1 << KEY_W);
    localparam logic [BIT_AW-1:0]  BIT_LAST    = '1;

    // operation kinds
    localparam logic [2:0] K_INSERT = 3'd0;
    localparam logic [2:0] K_REMOVE = 3'd1;
    localparam logic [2:0] K_MIN    = 3'd2;
    localparam logic [2:0] K_MAX    = 3'd3;
    localparam logic [2:0] K_PRED   = 3'd4;
    localparam logic [2:0] K_SUCC   = 3'd5;
    localparam logic [2:0] K_MEMBER = 3'd6;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // config register index
    localparam logic REG_KEY_LIMIT = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] bits;
        logic [BIT_AW-1:0] start;
        logic              down;
    } t_scan_req;

    typedef struct packed {
        logic              found;
        logic [BIT_AW-1:0] idx;
    } t_scan_rsp;

endpackage

`default_nettype wire

// ===== rtl/ordered_integer_set.sv =====
`default_nettype none

// Ordered set of 16-bit keys held as three levels of presence bitmaps: a
// 1024 x 64 leaf RAM (one bit per key), sixteen 64-bit mid words (one bit per
// nonempty leaf word) and a 16-bit top word. A small sequencer drives one
// shared masked first-one search unit over these levels, one level per cycle,
// and the block takes no new item until the result is in the output register.
// An out-of-range key or an unknown kind goes straight to the output stage.
// Insert and remove update the key's leaf word, member test reads it;
// minimum and maximum search from the bottom or top of the key space, and
// predecessor and successor from the key's neighbor after reading its leaf
// word. A search climbs the levels as far as it must (leaf, mid, top, then
// back down through mid and leaf, each a RAM or register read). A result
// waiting to be taken holds the block. A leaf word counts as zero whenever its
// mid bit is clear, so no clearing pass follows reset. Keys at or above
// key_limit are answered with an out-of-range status; stored keys are never
// dropped by a limit change.
module ordered_integer_set (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] key
    input  wire  [2:0]  s_axis_tuser,   // [2:0] kind
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] value, [16] was_present, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ois_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_KEY   = 4'd1;
    localparam logic [3:0] S_SRD   = 4'd2;
    localparam logic [3:0] S_LEAF  = 4'd3;
    localparam logic [3:0] S_MID   = 4'd4;
    localparam logic [3:0] S_TOP   = 4'd5;
    localparam logic [3:0] S_MID2  = 4'd6;
    localparam logic [3:0] S_FINAL = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [LIMIT_W-1:0]  key_limit;

    logic [3:0]          r_state, n_state;
    logic [2:0]          r_kind, n_kind;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [LIMIT_W-1:0]  r_s, n_s;
    logic                r_down, n_down;
    logic                r_present, n_present;
    logic [LEAF_AW-1:0]  r_w, n_w;
    logic [MID_AW-1:0]   r_mw, n_mw;
    logic [LEAF_AW-1:0]  r_rd_addr, n_rd_addr;
    logic                r_leaf_vld, n_leaf_vld;
    logic [1:0]          r_res_status, n_res_status;
    logic [KEY_W-1:0]    r_res_value, n_res_value;
    logic                r_res_present, n_res_present;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [KEY_W-1:0]    r_out_value, n_out_value;
    logic                r_out_present, n_out_present;
    logic [MID_WORDS-1:0] r_top, n_top;
    logic [WORD_W-1:0]   r_mid [MID_WORDS];

    logic [WORD_W-1:0]   leaf_mem [LEAF_WORDS];
    logic [WORD_W-1:0]   r_leaf_q;
    logic                mem_we, mem_re;
    logic [LEAF_AW-1:0]  mem_waddr, mem_raddr;
    logic [WORD_W-1:0]   mem_wdata;

    logic [MID_AW-1:0]   mid_addr;
    logic [WORD_W-1:0]   mid_rd;
    logic                mid_we;
    logic [WORD_W-1:0]   mid_wdata;

    logic [WORD_W-1:0]   eff_leaf;
    logic                in_fire;
    logic                out_free;
    logic                key_oor;
    t_scan_req           scan_req;
    t_scan_rsp           scan_rsp;

    ois_apb u_apb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_prdata    (prdata),
        .o_pready    (pready),
        .o_key_limit (key_limit)
    );

    ois_scan u_scan (
        .i_req (scan_req),
        .o_rsp (scan_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign key_oor       = {1'b0, s_axis_tdata} >= key_limit;
    assign eff_leaf      = r_leaf_vld ? r_leaf_q : '0;
    assign mid_rd        = r_mid[mid_addr];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {7'd0, r_out_present, r_out_value};

    // one mid read address per state
    always_comb begin
        mid_addr = r_key[KEY_W-1 -: MID_AW];
        case (r_state)
            S_IDLE: begin
                mid_addr = s_axis_tdata[KEY_W-1 -: MID_AW];
            end
            S_SRD: begin
                mid_addr = r_s[KEY_W-1 -: MID_AW];
            end
            S_MID: begin
                mid_addr = r_w[LEAF_AW-1 -: MID_AW];
            end
            S_MID2: begin
                mid_addr = r_mw;
            end
            default: begin
            end
        endcase
    end

    // one scan operand set per state
    always_comb begin
        scan_req.bits  = eff_leaf;
        scan_req.start = r_s[BIT_AW-1:0];
        scan_req.down  = r_down;
        case (r_state)
            S_MID: begin
                scan_req.bits  = mid_rd;
                scan_req.start = r_w[BIT_AW-1:0];
            end
            S_TOP: begin
                scan_req.bits  = WORD_W'(r_top);
                scan_req.start = BIT_AW'(r_mw);
            end
            S_MID2: begin
                scan_req.bits  = mid_rd;
                scan_req.start = r_down ? BIT_LAST : '0;
            end
            S_FINAL: begin
                scan_req.start = r_down ? BIT_LAST : '0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic [WORD_W-1:0]  key_bit;
        logic [WORD_W-1:0]  mid_bit;
        logic [MID_WORDS-1:0] top_bit;
        logic               present;
        logic [WORD_W-1:0]  new_leaf;
        logic               no_result;

        n_state       = r_state;
        n_kind        = r_kind;
        n_key         = r_key;
        n_s           = r_s;
        n_down        = r_down;
        n_present     = r_present;
        n_w           = r_w;
        n_mw          = r_mw;
        n_rd_addr     = r_rd_addr;
        n_leaf_vld    = r_leaf_vld;
        n_res_status  = r_res_status;
        n_res_value   = r_res_value;
        n_res_present = r_res_present;
        n_top         = r_top;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_value   = r_out_value;
        n_out_present = r_out_present;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = r_key[KEY_W-1:BIT_AW];
        mem_raddr     = r_key[KEY_W-1:BIT_AW];
        mem_wdata     = '0;
        mid_we        = 1'b0;
        mid_wdata     = mid_rd;
        no_result     = 1'b0;

        key_bit  = WORD_W'(1) << r_key[BIT_AW-1:0];
        mid_bit  = WORD_W'(1) << r_key[BIT_AW +: BIT_AW];
        top_bit  = MID_WORDS'(1) << r_key[KEY_W-1 -: MID_AW];
        present  = |(eff_leaf & key_bit);
        new_leaf = eff_leaf & ~key_bit;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_kind        = s_axis_tuser;
                    n_key         = s_axis_tdata;
                    n_present     = 1'b0;
                    n_res_status  = ST_OK;
                    n_res_value   = '0;
                    n_res_present = 1'b0;
                    if (s_axis_tuser == K_MIN) begin
                        n_s     = '0;
                        n_down  = 1'b0;
                        n_state = S_SRD;
                    end else if (s_axis_tuser == K_MAX) begin
                        n_s     = {1'b0, {KEY_W{1'b1}}};
                        n_down  = 1'b1;
                        n_state = S_SRD;
                    end else if (s_axis_tuser > K_MEMBER) begin
                        n_res_status = ST_NONE;
                        n_state      = S_DONE;
                    end else if (key_oor) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = s_axis_tdata[KEY_W-1:BIT_AW];
                        n_rd_addr  = s_axis_tdata[KEY_W-1:BIT_AW];
                        n_leaf_vld = mid_rd[s_axis_tdata[BIT_AW +: BIT_AW]];
                        n_down     = (s_axis_tuser == K_PRED);
                        // bit 16 of the start marks "no neighbor possible"
                        if (s_axis_tuser == K_PRED) begin
                            n_s = {1'b0, s_axis_tdata} - LIMIT_W'(1);
                        end else begin
                            n_s = {1'b0, s_axis_tdata} + LIMIT_W'(1);
                        end
                        n_state = S_KEY;
                    end
                end
            end
            S_KEY: begin
                n_present     = present;
                n_res_present = present;
                n_state       = S_DONE;
                case (r_kind)
                    K_INSERT: begin
                        if (!present) begin
                            mem_we    = 1'b1;
                            mem_wdata = eff_leaf | key_bit;
                            mid_we    = 1'b1;
                            mid_wdata = mid_rd | mid_bit;
                            n_top     = r_top | top_bit;
                        end
                    end
                    K_REMOVE: begin
                        if (present) begin
                            mem_we    = 1'b1;
                            mem_wdata = new_leaf;
                            if (new_leaf == '0) begin
                                mid_we    = 1'b1;
                                mid_wdata = mid_rd & ~mid_bit;
                                if ((mid_rd & ~mid_bit) == '0) begin
                                    n_top = r_top & ~top_bit;
                                end
                            end
                        end
                    end
                    K_MEMBER: begin
                        n_res_status = present ? ST_OK : ST_NONE;
                    end
                    default: begin
                        if (r_s[LIMIT_W-1]) begin
                            no_result = 1'b1;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                endcase
            end
            S_SRD: begin
                mem_re     = 1'b1;
                mem_raddr  = r_s[KEY_W-1:BIT_AW];
                n_rd_addr  = r_s[KEY_W-1:BIT_AW];
                n_leaf_vld = mid_rd[r_s[BIT_AW +: BIT_AW]];
                n_state    = S_LEAF;
            end
            S_LEAF: begin
                if (scan_rsp.found) begin
                    n_res_value = {r_s[KEY_W-1:BIT_AW], scan_rsp.idx};
                    n_state     = S_DONE;
                end else if (r_down) begin
                    if (r_s[KEY_W-1:BIT_AW] == '0) begin
                        no_result = 1'b1;
                    end else begin
                        n_w     = r_s[KEY_W-1:BIT_AW] - LEAF_AW'(1);
                        n_state = S_MID;
                    end
                end else begin
                    if (&r_s[KEY_W-1:BIT_AW]) begin
                        no_result = 1'b1;
                    end else begin
                        n_w     = r_s[KEY_W-1:BIT_AW] + LEAF_AW'(1);
                        n_state = S_MID;
                    end
                end
            end
            S_MID: begin
                if (scan_rsp.found) begin
                    mem_re     = 1'b1;
                    mem_raddr  = {r_w[LEAF_AW-1 -: MID_AW], scan_rsp.idx};
                    n_rd_addr  = {r_w[LEAF_AW-1 -: MID_AW], scan_rsp.idx};
                    n_leaf_vld = 1'b1;
                    n_state    = S_FINAL;
                end else if (r_down) begin
                    if (r_w[LEAF_AW-1 -: MID_AW] == '0) begin
                        no_result = 1'b1;
                    end else begin
                        n_mw    = r_w[LEAF_AW-1 -: MID_AW] - MID_AW'(1);
                        n_state = S_TOP;
                    end
                end else begin
                    if (&r_w[LEAF_AW-1 -: MID_AW]) begin
                        no_result = 1'b1;
                    end else begin
                        n_mw    = r_w[LEAF_AW-1 -: MID_AW] + MID_AW'(1);
                        n_state = S_TOP;
                    end
                end
            end
            S_TOP: begin
                if (scan_rsp.found) begin
                    n_mw    = scan_rsp.idx[MID_AW-1:0];
                    n_state = S_MID2;
                end else begin
                    no_result = 1'b1;
                end
            end
            S_MID2: begin
                mem_re     = 1'b1;
                mem_raddr  = {r_mw, scan_rsp.idx};
                n_rd_addr  = {r_mw, scan_rsp.idx};
                n_leaf_vld = 1'b1;
                n_state    = S_FINAL;
            end
            S_FINAL: begin
                n_res_value = {r_rd_addr, scan_rsp.idx};
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_value   = r_res_value;
                    n_out_present = r_res_present;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // membership of the queried key survives a failed neighbor search
        if (no_result) begin
            n_res_status  = ST_NONE;
            n_res_value   = '0;
            n_res_present = n_present;
            n_state       = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_top       <= '0;
            for (int i = 0; i < MID_WORDS; i++) begin
                r_mid[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_top       <= n_top;
            if (mid_we) begin
                r_mid[mid_addr] <= mid_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_key         <= n_key;
        r_s           <= n_s;
        r_down        <= n_down;
        r_present     <= n_present;
        r_w           <= n_w;
        r_mw          <= n_mw;
        r_rd_addr     <= n_rd_addr;
        r_leaf_vld    <= n_leaf_vld;
        r_res_status  <= n_res_status;
        r_res_value   <= n_res_value;
        r_res_present <= n_res_present;
        r_out_status  <= n_out_status;
        r_out_value   <= n_out_value;
        r_out_present <= n_out_present;
    end

    // leaf bitmap RAM, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            leaf_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_leaf_q <= leaf_mem[mem_raddr];
        end
    end

`ifndef ASSERT_OFF
    genvar g;
    generate
        for (g = 0; g < MID_WORDS; g++) begin : g_top_chk
            a_top_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_top[g] == (r_mid[g] != '0))
                else $error("top summary bit disagrees with mid word");
        end
    endgenerate

    a_mid2_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID2) |-> scan_rsp.found)
        else $error("mid word flagged in top summary is empty");

    a_final_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> (r_leaf_vld && scan_rsp.found))
        else $error("leaf word flagged in mid summary is empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/ois_scan.sv =====
`default_nettype none

// Masked first-one search over a 64-bit word. Upward: lowest set bit at or
// above start. Downward: highest set bit at or below start.
module ois_scan (
    input  ois_pkg::t_scan_req i_req,
    output ois_pkg::t_scan_rsp o_rsp
);
    import ois_pkg::*;

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] oriented;
    logic [WORD_W-1:0] iso;
    logic [BIT_AW-1:0] enc;

    always_comb begin
        if (i_req.down) begin
            mask = {WORD_W{1'b1}} >> (BIT_LAST - i_req.start);
        end else begin
            mask = {WORD_W{1'b1}} << i_req.start;
        end
        masked = i_req.bits & mask;
    end

    // reverse for the downward case so one lowest-bit isolate serves both
    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            oriented[i] = i_req.down ? masked[WORD_W-1-i] : masked[i];
        end
    end

    assign iso = oriented & (~oriented + WORD_W'(1));

    always_comb begin
        logic [BIT_AW-1:0] pos;
        enc = '0;
        for (int i = 0; i < WORD_W; i++) begin
            pos = BIT_AW'(i);
            enc = enc | ({BIT_AW{iso[i]}} & pos);
        end
    end

    assign o_rsp.found = |masked;
    assign o_rsp.idx   = i_req.down ? ~enc : enc;

endmodule

`default_nettype wire

// ===== rtl/ois_apb.sv =====
`default_nettype none

module ois_apb (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_psel,
    input  wire                           i_penable,
    input  wire                           i_pwrite,
    input  wire  [ois_pkg::APB_AW-1:0]    i_paddr,
    input  wire  [ois_pkg::APB_DW-1:0]    i_pwdata,
    output logic [ois_pkg::APB_DW-1:0]    o_prdata,
    output logic                          o_pready,
    output logic [ois_pkg::LIMIT_W-1:0]   o_key_limit
);
    import ois_pkg::*;

    logic [LIMIT_W-1:0] r_key_limit;
    logic               wr_hit;

    assign o_pready = 1'b1;
    assign wr_hit   = i_psel && i_penable && i_pwrite && o_pready
                      && (i_paddr[APB_AW-1] == REG_KEY_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_limit <= LIMIT_RESET;
        end else if (wr_hit) begin
            r_key_limit <= i_pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        if (i_paddr[APB_AW-1] == REG_KEY_LIMIT) begin
            o_prdata = APB_DW'(r_key_limit);
        end else begin
            o_prdata = '0;
        end
    end

    assign o_key_limit = r_key_limit;

endmodule

`default_nettype wire
